// ===== src/ffb_pkg.sv =====
// Shared types, field widths and constants of the forest fire burn unit.
package ffb_pkg;

  // Fixed field widths
  localparam int CoordW   = 6;
  localparam int SideRegW = 7;
  localparam int CountW   = 13;

  localparam logic [SideRegW-1:0] DefaultSide = 7'd20;
  localparam logic [CountW-1:0]   CountMax    = 13'd8191;

  // Cell encoding: bit 0 tree, bit 1 queued mark
  localparam int TreeBit = 0;
  localparam int MarkBit = 1;
  localparam logic [1:0] CellGround = 2'b00;
  localparam logic [1:0] CellTree   = 2'b01;
  localparam logic [1:0] CellQueued = 2'b11;

  // Eight neighbor offsets, walked in this order
  localparam int NbrCount = 8;
  localparam logic signed [1:0] StepX [NbrCount] =
    '{-2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] StepY [NbrCount] =
    '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd1};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_POP,
    ST_NBR,
    ST_ERASE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              was_tree;
    logic [CountW-1:0] burned_count;
    logic              rejected;
  } res_t;

endpackage

// ===== src/ffb_ram.sv =====
// Single write port, single read port memory with registered read data.
module ffb_ram #(
  parameter int DW = 2,
  parameter int AW = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data valid the cycle after the request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ffb_nbr.sv =====
// Neighbor address unit: one offset add and bounds compare per cycle.
module ffb_nbr
  import ffb_pkg::*;
#(
  parameter int CW    = 6,
  parameter int SideW = 7
) (
  input  logic [CW-1:0]    cur_x_i,
  input  logic [CW-1:0]    cur_y_i,
  input  logic [2:0]       k_i,
  input  logic [SideW-1:0] side_i,
  output logic             ok_o,
  output logic [2*CW-1:0]  addr_o
);

  localparam int LW = (CW + 1 > SideW) ? CW + 1 : SideW;

  logic [CW:0] nx;
  logic [CW:0] ny;

  // Offset the current cell; a step below zero wraps far above any side
  assign nx = {1'b0, cur_x_i} + (CW + 1)'(StepX[k_i]);
  assign ny = {1'b0, cur_y_i} + (CW + 1)'(StepY[k_i]);

  assign ok_o   = (LW'(nx) < LW'(side_i)) && (LW'(ny) < LW'(side_i));
  assign addr_o = {ny[CW-1:0], nx[CW-1:0]};

endmodule

// ===== src/ffb_ctrl.sv =====
// Event sequencer: reset sweep, target lookup, planting, breadth-first burn and map cleanup.
module ffb_ctrl
  import ffb_pkg::*;
#(
  parameter int CW    = 6,
  parameter int SideW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              kind_i,
  input  logic [CoordW-1:0] x_coord_i,
  input  logic [CoordW-1:0] y_coord_i,
  input  logic [SideW-1:0]  side_i,
  output logic              idle_o,
  output logic              res_valid_o,
  input  logic              res_take_i,
  output res_t              res_o
);

  localparam int AW = 2 * CW;
  localparam int TW = AW + 1;
  localparam int LW = (SideW > CoordW) ? SideW : CoordW;
  localparam int MW = (TW > CountW) ? TW : CountW;

  state_e            state_q, state_d;
  logic              kind_q, kind_d;
  logic [CW-1:0]     x_q, x_d;
  logic [CW-1:0]     y_q, y_d;
  logic              rej_q, rej_d;
  logic [TW-1:0]     head_q, head_d;
  logic [TW-1:0]     tail_q, tail_d;
  logic [3:0]        k_q, k_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              was_tree_q, was_tree_d;
  logic [CountW-1:0] count_q, count_d;

  logic          c_we, c_re;
  logic [AW-1:0] c_waddr, c_raddr;
  logic [1:0]    c_wdata, c_rdata;
  logic          q_we, q_re;
  logic [AW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  logic          nb_ok;
  logic [AW-1:0] nb_addr;

  ffb_ram #(.DW(2), .AW(AW)) u_cell_map (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  ffb_ram #(.DW(AW), .AW(AW)) u_fill_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  // Neighbors of the cell just popped from the queue
  ffb_nbr #(.CW(CW), .SideW(SideW)) u_nbr (
    .cur_x_i (q_rdata[CW-1:0]),
    .cur_y_i (q_rdata[AW-1:CW]),
    .k_i     (k_q[2:0]),
    .side_i  (side_i),
    .ok_o    (nb_ok),
    .addr_o  (nb_addr)
  );

  // Next state, memory requests and counters
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    x_d         = x_q;
    y_d         = y_q;
    rej_d       = rej_q;
    head_d      = head_q;
    tail_d      = tail_q;
    k_d         = k_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    clr_d       = clr_q;
    was_tree_d  = was_tree_q;
    count_d     = count_q;
    c_we        = 1'b0;
    c_waddr     = pend_addr_q;
    c_wdata     = CellGround;
    c_re        = 1'b0;
    c_raddr     = {y_q, x_q};
    q_we        = 1'b0;
    q_waddr     = tail_q[AW-1:0];
    q_wdata     = pend_addr_q;
    q_re        = 1'b0;
    q_raddr     = head_q[AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the map to ground after reset
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = CellGround;
        clr_d   = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          kind_d  = kind_i;
          x_d     = CW'(x_coord_i);
          y_d     = CW'(y_coord_i);
          rej_d   = (LW'(x_coord_i) >= LW'(side_i)) || (LW'(y_coord_i) >= LW'(side_i));
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (rej_q) begin
          was_tree_d = 1'b0;
          count_d    = '0;
          state_d    = ST_DONE;
        end else begin
          c_re    = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        was_tree_d = c_rdata[TreeBit];
        count_d    = '0;
        if (!kind_q) begin
          // Plant on ground only
          if (!c_rdata[TreeBit]) begin
            c_we    = 1'b1;
            c_waddr = {y_q, x_q};
            c_wdata = CellTree;
          end
          state_d = ST_DONE;
        end else if (c_rdata[TreeBit]) begin
          // Mark and queue the struck tree
          c_we    = 1'b1;
          c_waddr = {y_q, x_q};
          c_wdata = CellQueued;
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = {y_q, x_q};
          tail_d  = TW'(1);
          head_d  = '0;
          state_d = ST_POP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          head_d  = '0;
          pend_d  = 1'b0;
          state_d = ST_ERASE;
        end else begin
          q_re    = 1'b1;
          head_d  = head_q + 1'b1;
          k_d     = '0;
          pend_d  = 1'b0;
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        // Check the neighbor read last cycle; queue it if an unmarked tree
        if (pend_q && c_rdata[TreeBit] && !c_rdata[MarkBit]) begin
          c_we    = 1'b1;
          c_waddr = pend_addr_q;
          c_wdata = CellQueued;
          q_we    = 1'b1;
          q_waddr = tail_q[AW-1:0];
          q_wdata = pend_addr_q;
          tail_d  = tail_q + 1'b1;
        end
        if (k_q == 4'(NbrCount)) begin
          pend_d  = 1'b0;
          state_d = ST_POP;
        end else begin
          // Issue the read of the next neighbor
          pend_d      = nb_ok;
          pend_addr_d = nb_addr;
          c_re        = nb_ok;
          c_raddr     = nb_addr;
          k_d         = k_q + 1'b1;
        end
      end
      ST_ERASE: begin
        // Return every queued cell to ground
        if (pend_q) begin
          c_we    = 1'b1;
          c_waddr = q_rdata;
          c_wdata = CellGround;
        end
        if (head_q == tail_q) begin
          pend_d = 1'b0;
          if (MW'(tail_q) > MW'(CountMax)) begin
            count_d = CountMax;
          end else begin
            count_d = CountW'(tail_q);
          end
          state_d = ST_DONE;
        end else begin
          q_re   = 1'b1;
          head_d = head_q + 1'b1;
          pend_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    x_q         <= x_d;
    y_q         <= y_d;
    rej_q       <= rej_d;
    head_q      <= head_d;
    tail_q      <= tail_d;
    k_q         <= k_d;
    pend_addr_q <= pend_addr_d;
    was_tree_q  <= was_tree_d;
    count_q     <= count_d;
  end

  assign idle_o             = (state_q == ST_IDLE);
  assign res_valid_o        = (state_q == ST_DONE);
  assign res_o.was_tree     = was_tree_q;
  assign res_o.burned_count = count_q;
  assign res_o.rejected     = rej_q;

endmodule

// ===== src/forest_fire_flood_burn_unit.sv =====
// Top level of the forest fire burn unit: handshakes, side register, result register.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  kind_i, x_coord_i, y_coord_i
//   out      output     out_valid_o / out_stall_i was_tree_o, burned_count_o, rejected_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (grid_side)
//
// A rejected event goes to its result without a map access; a plant or a strike on
// ground reads the target cell first. A strike on a tree pops each burned cell from the
// queue and probes its eight neighbors through the shared address unit and the single
// map read port; afterwards every queued cell is returned to ground. After reset the
// map is swept to ground while in_stall_o stays high.
// A finished result waits in the output register while out_stall_i is high; the
// next item is taken meanwhile, and its result holds until the register drains.
module forest_fire_flood_burn_unit
  import ffb_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [CoordW-1:0]   x_coord_i,
  input  logic [CoordW-1:0]   y_coord_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                was_tree_o,
  output logic [CountW-1:0]   burned_count_o,
  output logic                rejected_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SideRegW-1:0] cfg_data_i
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int SideW = $clog2(MAX_SIDE + 1);

  logic [SideRegW-1:0] grid_side_q;
  logic [SideW-1:0]    side_use;
  logic                idle;
  logic                start;
  logic                res_valid;
  logic                res_take;
  res_t                res;
  logic                out_valid_q, out_valid_d;
  res_t                out_q;

  // Side register, written whenever a transfer arrives
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= DefaultSide;
    end else if (cfg_valid_i && cfg_ready_o) begin
      grid_side_q <= cfg_data_i;
    end
  end

  // Saturate the side in use at the map size
  assign side_use = (32'(grid_side_q) > MAX_SIDE) ? SideW'(MAX_SIDE) : SideW'(grid_side_q);

  assign in_stall_o = !idle;
  assign start      = in_valid_i && !in_stall_o;

  ffb_ctrl #(.CW(CW), .SideW(SideW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .side_i      (side_use),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Output register: load when empty or draining this cycle
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_tree_o     = out_q.was_tree;
  assign burned_count_o = out_q.burned_count;
  assign rejected_o     = out_q.rejected;

endmodule

// ===== verif/forest_fire_flood_burn_unit_tb.sv =====
// Testbench for the forest fire burn unit: directed and random events against a predictor.
`timescale 1ns / 100ps

module forest_fire_flood_burn_unit_tb;
  import ffb_pkg::*;

  localparam int GridMax       = 64;
  localparam int HalfPeriod    = 6;
  localparam int TimeoutCycles = 1_000_000;
  localparam int RandomItems   = 1875;
  localparam int IdlePercent   = 36;
  localparam bit KindPlant     = 1'b0;
  localparam bit KindStrike    = 1'b1;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                kind_i;
  logic [CoordW-1:0]   x_coord_i;
  logic [CoordW-1:0]   y_coord_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                was_tree_o;
  logic [CountW-1:0]   burned_count_o;
  logic                rejected_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [SideRegW-1:0] cfg_data_i;

  // Predictor state: tree bit per cell, side register as last written
  bit                  tree_map [GridMax*GridMax];
  logic [SideRegW-1:0] side_reg;
  res_t                pending_outcomes [$];
  res_t                due;
  int                  fail_count;
  int                  sent_count;
  bit                  steady;

  forest_fire_flood_burn_unit #(
    .MAX_SIDE(GridMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .was_tree_o    (was_tree_o),
    .burned_count_o(burned_count_o),
    .rejected_o    (rejected_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Apply one event to the predicted map and return its result
  function automatic res_t fire_outcome(input bit kind, input logic [CoordW-1:0] x,
                                        input logic [CoordW-1:0] y);
    res_t o;
    int   eff;
    int   idx;
    int   cur;
    int   nx;
    int   ny;
    int   burned;
    int   front [$];
    o = '0;
    eff = (side_reg > GridMax) ? GridMax : int'(side_reg);
    if (x >= eff || y >= eff) begin
      o.rejected = 1'b1;
      return o;
    end
    idx = int'(y) * GridMax + int'(x);
    o.was_tree = tree_map[idx];
    if (kind == KindPlant) begin
      tree_map[idx] = 1'b1;
    end else if (tree_map[idx]) begin
      // Breadth-first burn; clear on enqueue so no cell is taken twice
      burned = 0;
      tree_map[idx] = 1'b0;
      front.push_back(idx);
      while (front.size() != 0) begin
        cur = front.pop_front();
        burned++;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            nx = cur % GridMax + dx;
            ny = cur / GridMax + dy;
            if (nx >= 0 && ny >= 0 && nx < eff && ny < eff && tree_map[ny*GridMax+nx]) begin
              tree_map[ny*GridMax+nx] = 1'b0;
              front.push_back(ny * GridMax + nx);
            end
          end
        end
      end
      o.burned_count = (burned > int'(CountMax)) ? CountMax : CountW'(burned);
    end
    return o;
  endfunction

  // Offer one event, idling at random, and predict it once transferred
  task automatic send_event(input bit kind, input int x, input int y);
    res_t o;
    bit   done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if (!steady && $urandom_range(99) < IdlePercent) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        kind_i     <= kind;
        x_coord_i  <= CoordW'(x);
        y_coord_i  <= CoordW'(y);
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
        o = fire_outcome(kind, CoordW'(x), CoordW'(y));
        pending_outcomes.push_back(o);
        sent_count++;
        done = 1'b1;
      end
    end
  endtask

  // Hold the sender until every result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Write the side register with the block idle
  task automatic write_side(input int side);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= SideRegW'(side);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    side_reg = SideRegW'(side);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no event outstanding");
        fail_count++;
      end else begin
        due = pending_outcomes.pop_front();
        if (was_tree_o !== due.was_tree) begin
          $error("was_tree: expected %0d, got %0d", due.was_tree, was_tree_o);
          fail_count++;
        end
        if (burned_count_o !== due.burned_count) begin
          $error("burned_count: expected %0d, got %0d", due.burned_count, burned_count_o);
          fail_count++;
        end
        if (rejected_o !== due.rejected) begin
          $error("rejected: expected %0d, got %0d", due.rejected, rejected_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver stalls at random except in the steady stretch
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < IdlePercent);
  end

  // Reset side of 20, in range and out of range
  task automatic test_default_side();
    send_event(KindPlant, 19, 19);
    send_event(KindPlant, 20, 3);
    send_event(KindStrike, 19, 19);
  endtask

  // Side zero rejects all, oversize saturates, side one has a single cell
  task automatic test_side_extremes();
    write_side(0);
    send_event(KindStrike, 0, 0);
    write_side(127);
    send_event(KindPlant, 63, 63);
    send_event(KindPlant, 62, 62);
    send_event(KindPlant, 63, 63);
    send_event(KindStrike, 63, 63);
    send_event(KindStrike, 62, 62);
    write_side(1);
    send_event(KindPlant, 0, 0);
    send_event(KindStrike, 1, 0);
    send_event(KindStrike, 0, 0);
  endtask

  // Fire spreads diagonally from the border into a corner; a lone corner tree burns alone
  task automatic test_border_fire();
    write_side(8);
    send_event(KindPlant, 7, 7);
    send_event(KindPlant, 6, 6);
    send_event(KindPlant, 7, 5);
    send_event(KindPlant, 0, 0);
    send_event(KindStrike, 7, 5);
    send_event(KindStrike, 0, 0);
  endtask

  // Trees outside a shrunken grid survive a fire and remain afterwards
  task automatic test_shrink_side();
    write_side(64);
    send_event(KindPlant, 40, 40);
    send_event(KindPlant, 41, 41);
    write_side(41);
    send_event(KindStrike, 40, 40);
    write_side(64);
    send_event(KindStrike, 41, 41);
  endtask

  // Phases of random side; mostly planted clusters followed by a strike
  task automatic test_random_fires();
    int phase;
    int pick;
    int side;
    int eff;
    int budget;
    int n;
    int len;
    int sx;
    int sy;
    int cx;
    int cy;
    phase = 0;
    while (sent_count < RandomItems) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        side = $urandom_range(2, 12);
      end else if (pick < 80) begin
        side = $urandom_range(13, 40);
      end else if (pick < 92) begin
        side = GridMax;
      end else begin
        case ($urandom_range(3))
          0: side = 0;
          1: side = 1;
          2: side = 127;
          default: side = $urandom_range(65, 126);
        endcase
      end
      write_side(side);
      steady = (phase == 4);
      eff = (side > GridMax) ? GridMax : side;
      budget = $urandom_range(40, 120);
      n = 0;
      while (n < budget) begin
        if (eff >= 2 && $urandom_range(99) < 75) begin
          len = $urandom_range(1, 10);
          sx = $urandom_range(eff - 1);
          sy = $urandom_range(eff - 1);
          cx = sx;
          cy = sy;
          for (int i = 0; i < len; i++) begin
            send_event(KindPlant, cx, cy);
            cx = cx + $urandom_range(2) - 1;
            cy = cy + $urandom_range(2) - 1;
            cx = (cx < 0) ? 0 : (cx >= eff) ? eff - 1 : cx;
            cy = (cy < 0) ? 0 : (cy >= eff) ? eff - 1 : cy;
          end
          if ($urandom_range(1))
            send_event(KindStrike, sx, sy);
          else
            send_event(KindStrike, $urandom_range(eff - 1), $urandom_range(eff - 1));
          n += len + 1;
        end else begin
          send_event(bit'($urandom_range(1)), $urandom_range(63), $urandom_range(63));
          n++;
        end
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KindPlant;
    x_coord_i    = '0;
    y_coord_i    = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    side_reg     = DefaultSide;
    fail_count   = 0;
    sent_count   = 0;
    steady       = 1'b0;
    foreach (tree_map[i]) tree_map[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_side();
    test_side_extremes();
    test_border_fire();
    test_shrink_side();
    test_random_fires();

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #(TimeoutCycles * 2 * HalfPeriod);
    $display("simulation failed");
    $finish;
  end

endmodule
